// File: sv/thomson_scatter_cosine_sampler_assert.svh
// ----------------------------------------------------------------------------
// thomson scatter cosine sampler assertion macros
// shared concurrent assertion forms for the sampler rtl
// ----------------------------------------------------------------------------
`ifndef THOMSON_SCATTER_COSINE_SAMPLER_ASSERT_SVH
`define THOMSON_SCATTER_COSINE_SAMPLER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TSCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define TSCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/tscs_pkg.sv
// ----------------------------------------------------------------------------
// tscs_pkg
// widths and constants of the thomson scatter cosine sampler
// ----------------------------------------------------------------------------
package tscs_pkg;

   // fraction width of the random inputs and of the cosine scale
   localparam int RAND_BITS   = 16;

   // fixed field widths of the stream beats
   localparam int IN_FIELD_W  = 16;
   localparam int OUT_FIELD_W = 18;
   localparam int COUNT_W     = 32;
   localparam int REQ_DATA_W  = 2 * IN_FIELD_W;
   localparam int RSP_DATA_W  = ((OUT_FIELD_W + COUNT_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - OUT_FIELD_W - COUNT_W;

   // cube root datapath
   localparam int ROOT_W      = RAND_BITS + 1;          // root up to 2^RAND_BITS
   localparam int STEPS       = ROOT_W;                 // one root bit per step
   localparam int STEP_W      = $clog2(STEPS);
   localparam int RAD_W       = 3 * STEPS;              // radicand, 3 bits per step
   localparam int Y2_W        = 2 * ROOT_W;             // running square of the root
   localparam int B_W         = 2 * ROOT_W + 2;         // trial subtrahend
   localparam int REM_W       = 2 * ROOT_W + 4;         // partial remainder
   localparam int MU_W        = RAND_BITS + 2;          // signed cosine

   localparam logic [ROOT_W-1:0]    ONE     = {1'b1, {RAND_BITS{1'b0}}};
   localparam logic [RAND_BITS-1:0] THREE_Q = {2'b11, {(RAND_BITS-2){1'b0}}};
   localparam logic [RAND_BITS-1:0] HALF    = {1'b1, {(RAND_BITS-1){1'b0}}};
   localparam logic [COUNT_W-1:0]   COUNT_MAX = {COUNT_W{1'b1}};

endpackage

// File: sv/thomson_scatter_cosine_sampler.sv
// ----------------------------------------------------------------------------
// thomson scatter cosine sampler
// samples a scattering angle cosine by mixing a linear and a cube root branch
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents (lowest bit first)
//  --------+-----+-----------------------------------------------------------
//  req_    | in  | tdata: rand_first[15:0], rand_second[31:16]
//  rsp_    | out | tdata: angle_cosine[17:0], trial_count[49:18], zero pad
//          |     | tuser: cube_branch_used
//
//  linear branch: from the idle state straight to the result state
//  cube branch: through the 17 steps of the shared cube root unit first,
//  which settles one root bit per cycle
//  reset (synchronous, active high) clears the sequencer, the output valid and
//  the trial counter
//  a finished sample sits in the output register, so a new beat is taken while
//  the previous result waits; a stalled output holds the sequencer in its
//  result state only when a second result is already complete
//
module thomson_scatter_cosine_sampler (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tscs_pkg::REQ_DATA_W-1:0]  req_tdata,   // rand_first, rand_second
   // response stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tscs_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // angle_cosine, trial_count
   output logic                             rsp_tuser    // cube_branch_used
);

   `include "thomson_scatter_cosine_sampler_assert.svh"

   typedef enum logic [1:0] {
      S_IDLE,
      S_ROOT,
      S_DONE
   } state_type;

   // sequencer and counter
   state_type                          state_ff, state_in;
   logic [tscs_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [tscs_pkg::COUNT_W-1:0]       trials_ff, trials_in;

   // per-sample working registers
   logic                               cube_ff, cube_in;
   logic                               neg_ff, neg_in;
   logic signed [tscs_pkg::MU_W-1:0]   lin_ff, lin_in;
   logic [tscs_pkg::RAD_W-1:0]         rad_ff, rad_in;
   logic [tscs_pkg::REM_W-1:0]         rem_ff, rem_in;
   logic [tscs_pkg::ROOT_W-1:0]        y_ff, y_in;
   logic [tscs_pkg::Y2_W-1:0]          y2_ff, y2_in;

   // output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [tscs_pkg::OUT_FIELD_W-1:0]   rsp_mu_ff, rsp_mu_in;
   logic                               rsp_cube_ff, rsp_cube_in;
   logic [tscs_pkg::COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   // input decode
   logic                               accept;
   logic [tscs_pkg::RAND_BITS-1:0]     r1, r2;
   logic [tscs_pkg::ROOT_W-1:0]        r2x, lin_mag;
   logic                               cube_sel;

   // shared root step
   logic [2:0]                         digit;
   logic [tscs_pkg::REM_W-1:0]         rem_sh;
   logic [tscs_pkg::ROOT_W-1:0]        yd;
   logic [tscs_pkg::Y2_W-1:0]          y2d;
   logic [tscs_pkg::B_W-1:0]           b_base, b_val;
   logic                               fits;

   // result select
   logic signed [tscs_pkg::MU_W-1:0]   root_pos, mu_out;
   logic                               load_rsp;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign r1  = req_tdata[tscs_pkg::RAND_BITS-1:0];
   assign r2  = req_tdata[tscs_pkg::IN_FIELD_W +: tscs_pkg::RAND_BITS];
   assign r2x = {r2, 1'b0};
   assign cube_sel = (r1 > tscs_pkg::THREE_Q);   // three quarters exactly stays linear
   // |2*u2 - 1| in units of the fraction lsb
   assign lin_mag  = (r2 >= tscs_pkg::HALF) ? (r2x - tscs_pkg::ONE)
                                            : (tscs_pkg::ONE - r2x);

   // digit-by-digit cube root: bring in 3 radicand bits, try root bit 1
   assign digit  = rad_ff[tscs_pkg::RAD_W-1 -: 3];
   assign rem_sh = {rem_ff[tscs_pkg::REM_W-4:0], digit};
   assign yd     = {y_ff[tscs_pkg::ROOT_W-2:0], 1'b0};
   assign y2d    = {y2_ff[tscs_pkg::Y2_W-3:0], 2'b00};
   // b = 3*yd^2 + 3*yd + 1
   assign b_base = tscs_pkg::B_W'(y2d) + tscs_pkg::B_W'(yd);
   assign b_val  = {b_base[tscs_pkg::B_W-2:0], 1'b0} + b_base + tscs_pkg::B_W'(1);
   assign fits   = (rem_sh >= tscs_pkg::REM_W'(b_val));

   assign root_pos = $signed({1'b0, y_ff});
   assign mu_out   = cube_ff ? (neg_ff ? -root_pos : root_pos) : lin_ff;
   assign load_rsp = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      trials_in    = trials_ff;
      cube_in      = cube_ff;
      neg_in       = neg_ff;
      lin_in       = lin_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      y_in         = y_ff;
      y2_in        = y2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_mu_in    = rsp_mu_ff;
      rsp_cube_in  = rsp_cube_ff;
      rsp_count_in = rsp_count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // saturating sample counter, this beat included
               if (trials_ff != tscs_pkg::COUNT_MAX) begin
                  trials_in = trials_ff + tscs_pkg::COUNT_W'(1);
               end
               cube_in  = cube_sel;
               neg_in   = (r2 < tscs_pkg::HALF);
               lin_in   = $signed({1'b0, r2x}) - $signed({1'b0, tscs_pkg::ONE});
               // radicand = |2*u2 - 1| scaled by 2^(2*RAND_BITS)
               rad_in   = tscs_pkg::RAD_W'({lin_mag, {(2*tscs_pkg::RAND_BITS){1'b0}}});
               rem_in   = '0;
               y_in     = '0;
               y2_in    = '0;
               step_in  = tscs_pkg::STEP_W'(tscs_pkg::STEPS - 1);
               state_in = cube_sel ? S_ROOT : S_DONE;
            end
         end
         S_ROOT: begin
            rad_in = {rad_ff[tscs_pkg::RAD_W-4:0], 3'b000};
            if (fits) begin
               rem_in = rem_sh - tscs_pkg::REM_W'(b_val);
               y_in   = yd | tscs_pkg::ROOT_W'(1);
               y2_in  = y2d + tscs_pkg::Y2_W'({yd, 1'b1});
            end else begin
               rem_in = rem_sh;
               y_in   = yd;
               y2_in  = y2d;
            end
            step_in = step_ff - tscs_pkg::STEP_W'(1);
            if (step_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_mu_in    = tscs_pkg::OUT_FIELD_W'(mu_out);
               rsp_cube_in  = cube_ff;
               rsp_count_in = trials_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         trials_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         trials_ff    <= trials_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff      <= step_in;
      cube_ff      <= cube_in;
      neg_ff       <= neg_in;
      lin_ff       <= lin_in;
      rad_ff       <= rad_in;
      rem_ff       <= rem_in;
      y_ff         <= y_in;
      y2_ff        <= y2_in;
      rsp_mu_ff    <= rsp_mu_in;
      rsp_cube_ff  <= rsp_cube_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_cube_ff;
   assign rsp_tdata  = {{tscs_pkg::RSP_PAD_W{1'b0}}, rsp_count_ff, rsp_mu_ff};

   // ---- assertions ----

   `TSCS_ASSERT_NEXT(a_count_nonzero, clock, reset, accept,
                     trials_ff != '0, "counter zero after a sample")
   `TSCS_ASSERT_NEXT(a_cube_enters_root, clock, reset, accept && cube_sel,
                     state_ff == S_ROOT, "cube beat skipped the root unit")
   `TSCS_ASSERT_NEXT(a_lin_skips_root, clock, reset, accept && !cube_sel,
                     state_ff == S_DONE, "linear beat entered the root unit")
   `TSCS_ASSERT_NEXT(a_root_ends, clock, reset, (state_ff == S_ROOT) && (step_ff == '0),
                     state_ff == S_DONE, "root unit ran past its last step")
   `TSCS_ASSERT_NOW(a_root_bounded, clock, reset, (state_ff == S_DONE) && cube_ff,
                    y_ff <= tscs_pkg::ONE, "cube root above one")

endmodule
